@@ rtl/rsnp_pkg.sv @@
`default_nettype none
package rsnp_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int DIR_FRAC_BITS   = 14;
    localparam int PICK_KINDS      = 5;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int ID_W    = 32;
    localparam int KIND_W  = 4;
    localparam int DIST_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam int OC_W    = COORD_W + 1;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int B_W     = 50;
    localparam int B_SPLIT = 26;
    localparam int BH_W    = B_W - 1 - B_SPLIT;
    localparam int ACC_W   = 100;
    localparam int ROOT_W  = ACC_W / 2;
    localparam int SEL_W   = ROOT_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    // sphere radii with COORD_FRAC_BITS fraction bits, rounded half up
    localparam logic [MUL_W-1:0] RAD_MOB   =
        MUL_W'(((64'd110 << COORD_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [MUL_W-1:0] RAD_BOSS  =
        MUL_W'(((64'd240 << COORD_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [MUL_W-1:0] RAD_SMITH =
        MUL_W'(((64'd150 << COORD_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [MUL_W-1:0] RAD_CHEST =
        MUL_W'(((64'd90 << COORD_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [MUL_W-1:0] RAD_ROCK  =
        MUL_W'(((64'd120 << COORD_FRAC_BITS) + 64'd50) / 64'd100);

    typedef enum logic [1:0] {
        SH_NONE,
        SH_CROSS,
        SH_RAD,
        SH_HIGH
    } t_shift;

    typedef struct packed {
        logic   to_b;
        logic   neg;
        t_shift sh;
    } t_mac_ctl;

    function automatic logic [MUL_W-1:0] pick_radius(input logic [2:0] kind);
        logic [MUL_W-1:0] rad;
        unique case (kind)
            3'd0:    rad = RAD_MOB;
            3'd1:    rad = RAD_BOSS;
            3'd2:    rad = RAD_SMITH;
            3'd3:    rad = RAD_CHEST;
            3'd4:    rad = RAD_ROCK;
            default: rad = '0;
        endcase
        return rad;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rsnp_mac.sv @@
`default_nettype none
module rsnp_mac (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_clr,
    input  wire logic                                i_issue,
    input  wire logic signed [rsnp_pkg::MUL_W-1:0]   i_a,
    input  wire logic signed [rsnp_pkg::MUL_W-1:0]   i_b,
    input  wire rsnp_pkg::t_mac_ctl                  i_ctl,
    output logic signed [rsnp_pkg::B_W-1:0]          o_b,
    output logic signed [rsnp_pkg::ACC_W-1:0]        o_acc
);
    import rsnp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_ctl;
    logic                     r_pvalid;
    logic signed [B_W-1:0]    r_b;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  ext;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [ACC_W-1:0]  addend;

    always_comb begin
        ext = ACC_W'(r_prod);
        unique case (r_ctl.sh)
            SH_NONE:  shifted = ext;
            SH_CROSS: shifted = ext <<< (B_SPLIT + 1);
            SH_RAD:   shifted = ext <<< (2 * DIR_FRAC_BITS);
            SH_HIGH:  shifted = ext <<< (2 * B_SPLIT);
            default:  shifted = ext;
        endcase
        addend = r_ctl.neg ? -shifted : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_issue;
        end
        if (i_issue) begin
            r_prod <= i_a * i_b;
            r_ctl  <= i_ctl;
        end
        if (i_clr) begin
            r_b   <= '0;
            r_acc <= '0;
        end else if (r_pvalid) begin
            if (r_ctl.to_b) begin
                r_b <= r_b + B_W'(r_prod);
            end else begin
                r_acc <= r_acc + addend;
            end
        end
    end

    assign o_b   = r_b;
    assign o_acc = r_acc;

endmodule
`default_nettype wire

@@ rtl/rsnp_sqrt.sv @@
`default_nettype none
module rsnp_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rsnp_pkg::ACC_W-1:0]   i_n,
    output logic                              o_done,
    output logic [rsnp_pkg::ROOT_W-1:0]       o_root
);
    import rsnp_pkg::*;

    localparam int REM_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [ACC_W-1:0]  r_n;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  rem_s;
    logic [REM_W-1:0]  trial;

    always_comb begin
        rem_s = {r_rem[REM_W-3:0], r_n[ACC_W-1 -: 2]};
        trial = REM_W'({r_root, 2'b01});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_n    <= i_n;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                // one root bit per step, two radicand bits shifted in
                r_n <= r_n << 2;
                if (rem_s >= trial) begin
                    r_rem  <= rem_s - trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_s;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

@@ rtl/ray_sphere_nearest_pick_core.sv @@
// Nearest ray / sphere pick over a list of entities.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high (0..2 ray origin, 3..5 direction); only while no entity is in work.
// Input channel (i_valid / o_ready): one beat per entity. An entity that is
// inactive or of kind 5 and above goes from accept straight to pick; when the
// discriminant is negative it passes accept, the shared multiply-accumulate
// unit and pick; otherwise accept, multiply-accumulate, the bit-serial square
// root (50 root bits, one per cycle, then its done strobe), choosing the root
// and pick. o_ready is high only while no entity is in work.
// Output channel (o_valid / i_ready): one beat after the entity marked last,
// carrying the hit flag, id and distance of the nearest hit, or zeros.
// The result sits in an output register; a stalled receiver delays the
// block only when a further last entity finishes while that beat still
// waits. After each result the running best is cleared.
// Reset (synchronous, active low) clears the running best and the output
// valid flag and loads the default ray (origin zero, direction +x).
`default_nettype none
module ray_sphere_nearest_pick_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [rsnp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [rsnp_pkg::CFG_W-1:0]             i_cfg_data,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [rsnp_pkg::ID_W-1:0]              i_entity_id,
    input  wire logic [rsnp_pkg::KIND_W-1:0]            i_entity_kind,
    input  wire logic                                   i_is_active,
    input  wire logic signed [rsnp_pkg::COORD_W-1:0]    i_pos_x,
    input  wire logic signed [rsnp_pkg::COORD_W-1:0]    i_pos_y,
    input  wire logic signed [rsnp_pkg::COORD_W-1:0]    i_pos_z,
    input  wire logic                                   i_last_entity,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic                                        o_hit_found,
    output logic [rsnp_pkg::ID_W-1:0]                   o_best_entity_id,
    output logic [rsnp_pkg::DIST_W-1:0]                 o_best_distance
);
    import rsnp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_SQRT,
        S_EVAL,
        S_DONE
    } t_state;

    localparam logic [3:0] OP_BX   = 4'd0;
    localparam logic [3:0] OP_BY   = 4'd1;
    localparam logic [3:0] OP_BZ   = 4'd2;
    localparam logic [3:0] OP_OCX  = 4'd3;
    localparam logic [3:0] OP_OCY  = 4'd4;
    localparam logic [3:0] OP_OCZ  = 4'd5;
    localparam logic [3:0] OP_RAD  = 4'd6;
    localparam logic [3:0] OP_BLL  = 4'd7;
    localparam logic [3:0] OP_BHL  = 4'd8;
    localparam logic [3:0] OP_BHH  = 4'd9;
    localparam logic [3:0] OP_END  = 4'd10;
    localparam logic [3:0] OP_DRN  = 4'd11;

    t_state r_state;
    logic [3:0] r_op;

    logic signed [COORD_W-1:0] r_org_x, r_org_y, r_org_z;
    logic signed [DIR_W-1:0]   r_dir_x, r_dir_y, r_dir_z;

    logic signed [OC_W-1:0] r_oc_x, r_oc_y, r_oc_z;
    logic [ID_W-1:0]        r_id;
    logic [2:0]             r_kind;
    logic                   r_last;

    logic              r_cand_hit;
    logic [DIST_W-1:0] r_cand_dist;

    logic              r_run_hit;
    logic [ID_W-1:0]   r_run_id;
    logic [DIST_W-1:0] r_run_dist;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [ID_W-1:0]   r_out_id;
    logic [DIST_W-1:0] r_out_dist;

    logic accept;
    logic considered;
    logic issue;
    logic signed [MUL_W-1:0] op_a, op_b;
    t_mac_ctl op_ctl;
    logic signed [B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic [B_W-2:0]          b_mag;
    logic [B_SPLIT-1:0]      b_lo;
    logic [BH_W-1:0]         b_hi;
    logic                    sq_start;
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;

    logic signed [SEL_W-1:0] neg_b, near_t, far_t, sel_t;
    logic [SEL_W-DIR_FRAC_BITS-1:0] t_int;

    logic              take;
    logic              n_hit;
    logic [ID_W-1:0]   n_id;
    logic [DIST_W-1:0] n_dist;
    logic              out_free;

    assign accept     = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign considered = i_is_active && (i_entity_kind < KIND_W'(PICK_KINDS));
    assign issue      = (r_state == S_MAC) && (r_op < OP_END);
    assign sq_start   = (r_state == S_MAC) && (r_op == OP_DRN) && !mac_acc[ACC_W-1];

    always_comb begin
        b_mag = mac_b[B_W-1] ? (B_W-1)'(-mac_b) : mac_b[B_W-2:0];
        b_lo  = b_mag[B_SPLIT-1:0];
        b_hi  = b_mag[B_W-2:B_SPLIT];
    end

    always_comb begin
        op_ctl = '{to_b: 1'b0, neg: 1'b0, sh: SH_NONE};
        op_a   = '0;
        op_b   = '0;
        unique case (r_op)
            OP_BX: begin
                op_a = MUL_W'(r_oc_x); op_b = MUL_W'(r_dir_x); op_ctl.to_b = 1'b1;
            end
            OP_BY: begin
                op_a = MUL_W'(r_oc_y); op_b = MUL_W'(r_dir_y); op_ctl.to_b = 1'b1;
            end
            OP_BZ: begin
                op_a = MUL_W'(r_oc_z); op_b = MUL_W'(r_dir_z); op_ctl.to_b = 1'b1;
            end
            OP_OCX: begin
                op_a = MUL_W'(r_oc_x); op_b = MUL_W'(r_oc_x);
                op_ctl.neg = 1'b1; op_ctl.sh = SH_RAD;
            end
            OP_OCY: begin
                op_a = MUL_W'(r_oc_y); op_b = MUL_W'(r_oc_y);
                op_ctl.neg = 1'b1; op_ctl.sh = SH_RAD;
            end
            OP_OCZ: begin
                op_a = MUL_W'(r_oc_z); op_b = MUL_W'(r_oc_z);
                op_ctl.neg = 1'b1; op_ctl.sh = SH_RAD;
            end
            OP_RAD: begin
                op_a = pick_radius(r_kind); op_b = pick_radius(r_kind);
                op_ctl.sh = SH_RAD;
            end
            OP_BLL: begin
                op_a = MUL_W'(b_lo); op_b = MUL_W'(b_lo);
            end
            OP_BHL: begin
                op_a = MUL_W'(b_hi); op_b = MUL_W'(b_lo); op_ctl.sh = SH_CROSS;
            end
            OP_BHH: begin
                op_a = MUL_W'(b_hi); op_b = MUL_W'(b_hi); op_ctl.sh = SH_HIGH;
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    rsnp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (accept),
        .i_issue (issue),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_ctl   (op_ctl),
        .o_b     (mac_b),
        .o_acc   (mac_acc)
    );

    rsnp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (mac_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // near root, falling back to the far one when the origin is inside
    always_comb begin
        neg_b  = -SEL_W'(mac_b);
        near_t = neg_b - SEL_W'(sq_root);
        far_t  = neg_b + SEL_W'(sq_root);
        sel_t  = near_t[SEL_W-1] ? far_t : near_t;
        t_int  = sel_t[SEL_W-1:DIR_FRAC_BITS];
    end

    always_comb begin
        take   = r_cand_hit && (!r_run_hit || (r_cand_dist < r_run_dist));
        n_hit  = take ? 1'b1 : r_run_hit;
        n_id   = take ? r_id : r_run_id;
        n_dist = take ? r_cand_dist : r_run_dist;
        out_free = !r_out_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= '0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
            r_dir_x     <= DIR_W'(16384);
            r_dir_y     <= '0;
            r_dir_z     <= '0;
            r_run_hit   <= 1'b0;
            r_run_id    <= '0;
            r_run_dist  <= '1;
            r_out_valid <= 1'b0;
            r_cand_hit  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                    CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                    CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                    CFG_DIR_X:    r_dir_x <= i_cfg_data[DIR_W-1:0];
                    CFG_DIR_Y:    r_dir_y <= i_cfg_data[DIR_W-1:0];
                    CFG_DIR_Z:    r_dir_z <= i_cfg_data[DIR_W-1:0];
                    default: ;
                endcase
            end
            // drop the beat once taken, unless a new result replaces it
            if (r_out_valid && i_ready && !(r_state == S_DONE && r_last)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_id       <= i_entity_id;
                        r_kind     <= i_entity_kind[2:0];
                        r_last     <= i_last_entity;
                        r_oc_x     <= OC_W'(r_org_x) - OC_W'(i_pos_x);
                        r_oc_y     <= OC_W'(r_org_y) - OC_W'(i_pos_y);
                        r_oc_z     <= OC_W'(r_org_z) - OC_W'(i_pos_z);
                        r_op       <= '0;
                        r_cand_hit <= 1'b0;
                        r_state    <= considered ? S_MAC : S_DONE;
                    end
                end
                S_MAC: begin
                    r_op <= r_op + 1'b1;
                    if (r_op == OP_DRN) begin
                        // negative discriminant: the ray misses
                        r_state <= mac_acc[ACC_W-1] ? S_DONE : S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_cand_hit  <= !sel_t[SEL_W-1];
                    r_cand_dist <= (|t_int[SEL_W-DIR_FRAC_BITS-1:DIST_W]) ?
                                   '1 : t_int[DIST_W-1:0];
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_last) begin
                        r_run_hit  <= n_hit;
                        r_run_id   <= n_id;
                        r_run_dist <= n_dist;
                        r_state    <= S_IDLE;
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= n_hit;
                        r_out_id    <= n_hit ? n_id : '0;
                        r_out_dist  <= n_hit ? n_dist : '0;
                        r_run_hit   <= 1'b0;
                        r_run_id    <= '0;
                        r_run_dist  <= '1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_hit_found      = r_out_hit;
    assign o_best_entity_id = r_out_id;
    assign o_best_distance  = r_out_dist;

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run_hit |-> (r_run_id == '0) && (r_run_dist == '1))
        else $error("running best not clear without a hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_found |-> (o_best_entity_id == '0) && (o_best_distance == '0))
        else $error("miss result carries non-zero payload");

    a_no_issue_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> !issue && !sq_start)
        else $error("shared unit issued during square root");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE) && $past(r_last))
        else $error("result raised without a last entity");

endmodule
`default_nettype wire
